@@ rtl/nca_pkg.sv @@
// nca_pkg: shared types and constants for the nearest-centroid assign unit
// used by nca_cell and nearest_centroid_assign_unit; no dependencies
`default_nettype none

package nca_pkg;

  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned CLUSTER_W   = 4;
  localparam int unsigned ACTIVE_W    = 5;
  localparam int unsigned DIST_OUT_W  = 33;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd10;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_t;

  // control part of one beat travelling down the cell chain
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } ctl_t;

endpackage : nca_pkg

`default_nettype wire

@@ rtl/nearest_centroid_assign_unit.sv @@
// nearest_centroid_assign_unit: top level, a chain of MAX_CENTROIDS centroid cells
// depends on nca_pkg and nca_cell
// throughput: one item per cycle, busy stays low; loads and points share the chain
// each cell adds two register stages (square, then sum and compare)
// reset clears the centroid table to zero and sets active_clusters to 10
`default_nettype none

module nearest_centroid_assign_unit #(
  parameter int unsigned MAX_CENTROIDS = 16,
  parameter int unsigned COORD_BITS    = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_opcode,
  input  wire logic [nca_pkg::SLOT_W-1:0]          in_centroid_slot,
  input  wire logic signed [COORD_BITS-1:0]        in_coord_x,
  input  wire logic signed [COORD_BITS-1:0]        in_coord_y,
  input  wire logic                                in_last_point,
  output logic                                     out_valid,
  output logic [nca_pkg::CLUSTER_W-1:0]            out_cluster_index,
  output logic [nca_pkg::DIST_OUT_W-1:0]           out_best_distance_sq,
  output logic                                     out_end_of_pass,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [nca_pkg::ACTIVE_W-1:0]        cfg_active_clusters
);
  import nca_pkg::*;

  // squared distance width, capped at 64 bits for the widest coordinates
  localparam int unsigned DIST_W = (2 * COORD_BITS + 2 > 64) ? 64 : 2 * COORD_BITS + 2;

  logic [ACTIVE_W-1:0] active_r, active_nxt;

  ctl_t                         chain_ctl  [MAX_CENTROIDS+1];
  logic signed [COORD_BITS-1:0] chain_x    [MAX_CENTROIDS+1];
  logic signed [COORD_BITS-1:0] chain_y    [MAX_CENTROIDS+1];
  logic [DIST_W-1:0]            chain_best [MAX_CENTROIDS+1];
  logic [CLUSTER_W-1:0]         chain_idx  [MAX_CENTROIDS+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_comb begin
    active_nxt = (cfg_valid && cfg_ready) ? cfg_active_clusters : active_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else begin
      active_r <= active_nxt;
    end
  end

  // beat entering the head of the chain
  always_comb begin
    chain_ctl[0].valid = start && !busy;
    chain_ctl[0].op    = op_t'(in_opcode);
    chain_ctl[0].slot  = in_centroid_slot;
    chain_ctl[0].last  = in_last_point;
    chain_x[0]         = in_coord_x;
    chain_y[0]         = in_coord_y;
    chain_best[0]      = '0;
    chain_idx[0]       = '0;
  end

  for (genvar g = 0; g < MAX_CENTROIDS; g++) begin : g_cell
    nca_cell #(
      .IDX        (g),
      .COORD_BITS (COORD_BITS),
      .DIST_W     (DIST_W)
    ) u_cell (
      .clk             (clk),
      .rst_n           (rst_n),
      .active_clusters (active_r),
      .in_ctl          (chain_ctl[g]),
      .in_x            (chain_x[g]),
      .in_y            (chain_y[g]),
      .in_best         (chain_best[g]),
      .in_idx          (chain_idx[g]),
      .out_ctl         (chain_ctl[g+1]),
      .out_x           (chain_x[g+1]),
      .out_y           (chain_y[g+1]),
      .out_best        (chain_best[g+1]),
      .out_idx         (chain_idx[g+1])
    );
  end

  // results leave straight from the last cell's registers
  always_comb begin
    out_valid            = chain_ctl[MAX_CENTROIDS].valid
                           && (chain_ctl[MAX_CENTROIDS].op == OP_CLASSIFY);
    out_cluster_index    = chain_idx[MAX_CENTROIDS];
    out_best_distance_sq = DIST_OUT_W'(chain_best[MAX_CENTROIDS]);
    out_end_of_pass      = chain_ctl[MAX_CENTROIDS].last;
  end

endmodule : nearest_centroid_assign_unit

`default_nettype wire

@@ rtl/nca_cell.sv @@
// nca_cell: one centroid cell of the assign chain, two register stages
// stage 1 squares the coordinate differences, stage 2 sums and keeps the best
// depends on nca_pkg
`default_nettype none

module nca_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned DIST_W     = 34
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [nca_pkg::ACTIVE_W-1:0]      active_clusters,
  input  wire nca_pkg::ctl_t                     in_ctl,
  input  wire logic signed [COORD_BITS-1:0]      in_x,
  input  wire logic signed [COORD_BITS-1:0]      in_y,
  input  wire logic [DIST_W-1:0]                 in_best,
  input  wire logic [nca_pkg::CLUSTER_W-1:0]     in_idx,
  output nca_pkg::ctl_t                          out_ctl,
  output logic signed [COORD_BITS-1:0]           out_x,
  output logic signed [COORD_BITS-1:0]           out_y,
  output logic [DIST_W-1:0]                      out_best,
  output logic [nca_pkg::CLUSTER_W-1:0]          out_idx
);
  import nca_pkg::*;

  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned SQ_W   = 2 * DIFF_W;
  localparam bit          SLOT_REACHABLE = (IDX < (1 << SLOT_W));
  localparam logic [6:0]  IDX_CMP = 7'(IDX);
  localparam logic [CLUSTER_W-1:0] IDX_TAG = CLUSTER_W'(IDX);

  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic signed [COORD_BITS-1:0] cx_nxt, cy_nxt;

  ctl_t                         ctl_s1_r;
  logic signed [COORD_BITS-1:0] x_s1_r, y_s1_r;
  logic [DIST_W-1:0]            best_s1_r;
  logic [CLUSTER_W-1:0]         idx_s1_r;
  logic [DIST_W-1:0]            sqx_s1_r, sqy_s1_r;
  logic [DIST_W-1:0]            sqx_s1_nxt, sqy_s1_nxt;

  ctl_t                         ctl_r;
  logic signed [COORD_BITS-1:0] x_r, y_r;
  logic [DIST_W-1:0]            best_r, best_nxt;
  logic [CLUSTER_W-1:0]         idx_r, idx_nxt;

  logic                         load_hit;
  logic signed [DIFF_W-1:0]     dx, dy;
  logic [DIFF_W-1:0]            mag_x, mag_y;
  logic [SQ_W-1:0]              sqx_full, sqy_full;
  logic [DIST_W-1:0]            dist_sum;
  logic                         active;
  logic                         take;

  // centroid capture: a load beat writes the cell whose index matches its slot
  always_comb begin
    load_hit = SLOT_REACHABLE && in_ctl.valid && (in_ctl.op == OP_LOAD)
               && (in_ctl.slot == SLOT_W'(IDX));
    cx_nxt = load_hit ? in_x : cx_r;
    cy_nxt = load_hit ? in_y : cy_r;
  end

  // stage 1: differences and squares
  always_comb begin
    dx = DIFF_W'(in_x) - DIFF_W'(cx_r);
    dy = DIFF_W'(in_y) - DIFF_W'(cy_r);
    mag_x = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    mag_y = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    sqx_full = SQ_W'(mag_x) * SQ_W'(mag_x);
    sqy_full = SQ_W'(mag_y) * SQ_W'(mag_y);
    sqx_s1_nxt = DIST_W'(sqx_full);
    sqy_s1_nxt = DIST_W'(sqy_full);
  end

  // stage 2: sum and strict less-than against the running best; cell 0 always takes
  always_comb begin
    dist_sum = sqx_s1_r + sqy_s1_r;
    active   = (IDX == 0) || (IDX_CMP < {2'b00, active_clusters});
    take     = (IDX == 0) || (active && (dist_sum < best_s1_r));
    best_nxt = take ? dist_sum : best_s1_r;
    idx_nxt  = take ? IDX_TAG : idx_s1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      ctl_s1_r <= '0;
      ctl_r    <= '0;
    end else begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      ctl_s1_r <= in_ctl;
      ctl_r    <= ctl_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    x_s1_r    <= in_x;
    y_s1_r    <= in_y;
    best_s1_r <= in_best;
    idx_s1_r  <= in_idx;
    sqx_s1_r  <= sqx_s1_nxt;
    sqy_s1_r  <= sqy_s1_nxt;
    x_r       <= x_s1_r;
    y_r       <= y_s1_r;
    best_r    <= best_nxt;
    idx_r     <= idx_nxt;
  end

  assign out_ctl  = ctl_r;
  assign out_x    = x_r;
  assign out_y    = y_r;
  assign out_best = best_r;
  assign out_idx  = idx_r;

`ifndef NO_ASSERTIONS
  // centroid changes only under a matching load beat
  a_centroid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load_hit |=> ($stable(cx_r) && $stable(cy_r)))
    else $error("centroid changed without a matching load");

  // past the first cell the running best can only shrink
  a_best_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    (IDX != 0) && ctl_s1_r.valid && (ctl_s1_r.op == OP_CLASSIFY)
    |=> (best_r <= $past(best_s1_r)))
    else $error("running best grew in cell");

  // an inactive cell passes the running result through untouched
  a_inactive_pass: assert property (@(posedge clk) disable iff (!rst_n)
    !active && ctl_s1_r.valid && (ctl_s1_r.op == OP_CLASSIFY)
    |=> ((best_r == $past(best_s1_r)) && (idx_r == $past(idx_s1_r))))
    else $error("inactive cell altered the result");
`endif

endmodule : nca_cell

`default_nettype wire
